// ===== rtl/core/dpma_pkg.sv =====
// Shared types and constants for the distance percent median alarm core.
package dpma_pkg;

  localparam int DistW = 9;
  localparam int PctW  = 7;
  localparam int QuoW  = 16;
  localparam int CntDivW = 4;

  localparam logic [PctW-1:0] PctFull   = 7'd100;
  localparam logic [PctW-1:0] EmptyCode = 7'd127;
  localparam logic [15:0]     DistanceMax = 16'd400;

  localparam logic [DistW-1:0] NearReset  = 9'd50;
  localparam logic [DistW-1:0] FarReset   = 9'd250;
  localparam logic [PctW-1:0]  AlarmReset = 7'd50;

  localparam logic [1:0] RegNear  = 2'd0;
  localparam logic [1:0] RegFar   = 2'd1;
  localparam logic [1:0] RegAlarm = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic            done;
    logic [PctW-1:0] value;
  } pct_res_t;

  typedef struct packed {
    logic [PctW-1:0] value;
    logic            gt;
  } cell_link_t;

endpackage

// ===== rtl/core/distance_percent_median_alarm_core.sv =====
// Top level: percent conversion, sorted batch chain, median and alarm output.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | distance_cm[8:0]
//  out     | output    | out_valid / out_stall| median_percent[6:0], alarm
//  cfg     | input     | psel/penable/pwrite  | paddr[3:0], pwdata, prdata
//
// A word runs through the 16-step serial divider before the next word is
// accepted. No echo, out of range, below near or a bad span skip the
// divider. The last word of a batch adds the emit state to load the output
// register and clear the chain, and waits there while a previous result is
// still stalled. rst is synchronous and empties the chain.
module distance_percent_median_alarm_core import dpma_pkg::*; #(
  parameter int WINDOW = 51
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [DistW-1:0] distance_cm,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PctW-1:0]  median_percent,
  output logic             alarm,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int CntW = $clog2(WINDOW);

  state_t            state;
  state_t            state_next;
  logic [CntW-1:0]   count;
  logic [DistW-1:0]  near_cm;
  logic [DistW-1:0]  far_cm;
  logic [PctW-1:0]   alarm_level;
  logic              accept;
  logic              load_out;
  logic              last;
  pct_res_t          res;
  cell_link_t        cl [WINDOW];
  cell_link_t        head;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_cm     <= NearReset;
      far_cm      <= FarReset;
      alarm_level <= AlarmReset;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegNear:  near_cm     <= pwdata[DistW-1:0];
        RegFar:   far_cm      <= pwdata[DistW-1:0];
        RegAlarm: alarm_level <= pwdata[PctW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegNear:  prdata = 32'(near_cm);
      RegFar:   prdata = 32'(far_cm);
      RegAlarm: prdata = 32'(alarm_level);
      default:  prdata = '0;
    endcase
  end

  assign last = count == CntW'(WINDOW - 1);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_CALC;
      ST_CALC: if (res.done) state_next = last ? ST_EMIT : ST_IDLE;
      ST_EMIT: if (load_out) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = state != ST_IDLE;
    accept   = in_valid && (state == ST_IDLE);
    load_out = (state == ST_EMIT) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res.done) begin
        count <= last ? '0 : count + 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      median_percent <= cl[WINDOW/2].value;
      alarm          <= cl[WINDOW/2].value >= alarm_level;
    end
  end

  dpma_pct u_pct (
    .clk         (clk),
    .rst         (rst),
    .start       (accept),
    .distance_cm (distance_cm),
    .near_cm     (near_cm),
    .far_cm      (far_cm),
    .res         (res)
  );

  assign head.value = EmptyCode;
  assign head.gt    = 1'b0;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    dpma_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .clear  (load_out),
      .insert (res.done),
      .x      (res.value),
      .left   ((i == 0) ? head : cl[(i == 0) ? 0 : i - 1]),
      .right  (cl[i])
    );
  end

  a_accept_calc: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_CALC)
    else $error("accepted word did not start a conversion");

  a_done_in_calc: assert property (@(posedge clk) disable iff (rst)
    res.done |-> state == ST_CALC)
    else $error("converter finished outside a conversion");

  a_full_at_emit: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> cl[WINDOW-1].value <= PctFull)
    else $error("chain not full when emitting a median");

  a_rose_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_EMIT))
    else $error("result appeared without a finished batch");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, count} < (CntW + 1)'(WINDOW))
    else $error("sample count past batch size");

endmodule

// ===== rtl/core/dpma_pct.sv =====
// Distance to inverted percent converter with a bit-serial restoring divider.
module dpma_pct import dpma_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DistW-1:0] distance_cm,
  input  logic [DistW-1:0] near_cm,
  input  logic [DistW-1:0] far_cm,
  output pct_res_t         res
);

  logic               busy;
  logic               done;
  logic [CntDivW-1:0] cnt;
  logic [DistW-1:0]   rem;
  logic [DistW-1:0]   rem_next;
  logic [QuoW-1:0]    quo;
  logic [QuoW-1:0]    quo_next;
  logic [DistW-1:0]   span;
  logic [PctW-1:0]    value;
  logic [DistW:0]     rem_sh;
  logic               ge;
  logic [PctW-1:0]    clip;
  logic               special;
  logic               last;
  logic [QuoW-1:0]    prod;

  always_comb begin
    special = (distance_cm == '0) || (16'(distance_cm) > DistanceMax) ||
              (far_cm <= near_cm) || (distance_cm < near_cm);
    prod    = QuoW'(distance_cm - near_cm) * QuoW'(PctFull);
    rem_sh  = {rem, quo[QuoW-1]};
    ge      = rem_sh >= {1'b0, span};
    rem_next = ge ? DistW'(rem_sh - {1'b0, span}) : rem_sh[DistW-1:0];
    quo_next = {quo[QuoW-2:0], ge};
    clip    = (quo_next > QuoW'(PctFull)) ? PctFull : quo_next[PctW-1:0];
    last    = cnt == CntDivW'(QuoW - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= (start && special) || (!start && busy && last);
      if (start) begin
        cnt  <= '0;
        busy <= !special;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      if (special) begin
        value <= PctFull;
      end else begin
        quo  <= prod;
        rem  <= '0;
        span <= far_cm - near_cm;
      end
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
      if (last) begin
        value <= PctFull - clip;
      end
    end
  end

  assign res.done  = done;
  assign res.value = value;

endmodule

// ===== rtl/core/dpma_cell.sv =====
// One cell of the insertion sort chain; empty cells hold the top code.
module dpma_cell import dpma_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            clear,
  input  logic            insert,
  input  logic [PctW-1:0] x,
  input  cell_link_t      left,
  output cell_link_t      right
);

  logic [PctW-1:0] value;
  logic            gt;

  assign gt = value > x;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      value <= EmptyCode;
    end else if (insert && gt) begin
      value <= left.gt ? left.value : x;
    end
  end

  assign right.value = value;
  assign right.gt    = gt;

endmodule
